// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define DTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: rtl/dtt_pkg.sv
// ----------------------------------------------------------------------------
// dtt_pkg
// Types and constants of the deadline timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtt_pkg;

   // most fire results one tick may produce
   localparam int MAX_FIRES = 16;
   localparam int FIRE_W    = $clog2(MAX_FIRES + 1);

   // index fields in the cell control beat cover the largest table (256)
   localparam int IDX_FIELD_W = 9;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_ADD  = 1'b1;

   localparam logic [1:0] KIND_FIRED = 2'd0;
   localparam logic [1:0] KIND_ADDED = 2'd1;
   localparam logic [1:0] KIND_FULL  = 2'd2;

   typedef struct packed {
      logic        command;
      logic [30:0] offset_seconds;
      logic [30:0] period_seconds;
      logic [7:0]  action_id;
      logic [31:0] param_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  fired_action;
      logic [31:0] fired_param;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] deadline;
      logic [30:0] period;
      logic [7:0]  action;
      logic [31:0] param;
   } entry_type;

   typedef struct packed {
      logic                   shift;
      logic [IDX_FIELD_W-1:0] hold_below;
      logic                   load;
      logic [IDX_FIELD_W-1:0] load_idx;
      entry_type              load_entry;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

// File: rtl/dtt_cell.sv
// ----------------------------------------------------------------------------
// dtt_cell
// One timer entry slot of the chain. Loads a new entry when addressed by an
// add, otherwise takes its lower neighbor's entry on a shift unless it sits
// below the hold boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module dtt_cell #(
   parameter int CELL_IDX = 0
) (
   input  wire                     clock,
   input  dtt_pkg::cell_ctrl_type  ctrl,
   input  dtt_pkg::entry_type      below,
   output dtt_pkg::entry_type      q
);
   import dtt_pkg::*;

   localparam logic [IDX_FIELD_W-1:0] MY_IDX = IDX_FIELD_W'(CELL_IDX);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load && ctrl.load_idx == MY_IDX) begin
         entry_in = ctrl.load_entry;
      end else if (ctrl.shift && MY_IDX >= ctrl.hold_below) begin
         entry_in = below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign q = entry_ff;

endmodule

`default_nettype wire

// File: rtl/deadline_timer_table_core.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_core
// Table of one-shot and periodic timers kept in a chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries commands: an add appends an entry due at now + offset, a
//   tick advances the seconds counter (while enabled) and fires due entries.
//   rsp_* returns result beats; last marks the final beat of a command.
//   csr_* writes timer_enable; write it only while the block is idle.
// Latency / throughput:
//   An add answers in the cycle after acceptance and the next command may
//   follow as soon as that beat can be taken. An enabled tick scans the
//   table one entry per cycle while no fire beat stalls, as the cell chain
//   shifts one place toward the top cell, and then hands out the final
//   fire beat in a flush state when anything fired. A disabled tick is
//   absorbed with no result.
// Stalls: the scan holds in place whenever a fire beat cannot enter the
//   output register; results are never dropped.
// Reset: time, entry count and enable clear to zero; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_table_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  dtt_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output dtt_pkg::rsp_type  rsp_data,
   input  wire               csr_valid,
   output logic              csr_ready,
   input  wire               csr_data
);
   import dtt_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   state_type         state_ff, state_in;
   logic              enable_ff;
   logic [31:0]       now_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  kept_ff;
   logic [IDX_W-1:0]  step_ff;
   logic [FIRE_W-1:0] fired_ff;
   logic              pend_valid_ff;
   logic [7:0]        pend_action_ff;
   logic [31:0]       pend_param_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   entry_type     cell_q   [TABLE_DEPTH];
   entry_type     chain_in [TABLE_DEPTH];
   entry_type     top_entry;
   entry_type     wrap_entry;
   cell_ctrl_type cell_ctrl;

   logic             can_load;
   logic             req_fire;
   logic             is_add;
   logic             tbl_full;
   logic             tick_start;
   logic [CNT_W:0]   pre_sum;
   logic             pre_slot;
   logic             examine;
   logic [31:0]      age;
   logic             due_hit;
   logic             remove;
   logic             need_out;
   logic             advance;
   logic             last_step;
   logic [CNT_W-1:0] kept_next;
   logic             rsp_load;
   rsp_type          rsp_next;

   // ---------------------------------------------------------------- cells
   assign top_entry = cell_q[TABLE_DEPTH-1];

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign chain_in[g] = wrap_entry;
      end else begin : g_rest
         assign chain_in[g] = cell_q[g-1];
      end
      dtt_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock (clock),
         .ctrl  (cell_ctrl),
         .below (chain_in[g]),
         .q     (cell_q[g])
      );
   end

   // ---------------------------------------------------------------- control
   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign is_add    = (req_data.command == CMD_ADD);
   assign tbl_full  = (count_ff == CNT_W'(TABLE_DEPTH));
   assign last_step = (step_ff == IDX_W'(TABLE_DEPTH - 1));
   assign age       = now_ff - top_entry.deadline;

   // slots above the fill count pass through the top cell without a look
   assign pre_sum  = (CNT_W + 1)'(step_ff) + (CNT_W + 1)'(count_ff);
   assign pre_slot = (pre_sum < (CNT_W + 1)'(TABLE_DEPTH));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && !is_add && enable_ff) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (advance && last_step) begin
               state_in = (pend_valid_ff || due_hit) ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (can_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = (state_ff == ST_IDLE) && can_load;
      req_fire   = req_valid && req_ready;
      tick_start = req_fire && !is_add && enable_ff;
      examine    = (state_ff == ST_SCAN) && !pre_slot;
      due_hit    = examine && (fired_ff < FIRE_W'(MAX_FIRES)) && !age[31];
      remove     = due_hit && (top_entry.period == '0);
      need_out   = due_hit && pend_valid_ff;
      advance    = (state_ff == ST_SCAN) && (!need_out || can_load);
      kept_next  = kept_ff + CNT_W'(examine && !remove);

      // kept entries drop back in at the bottom; periodic hits are rearmed
      wrap_entry = top_entry;
      if (due_hit && !remove) begin
         wrap_entry.deadline = now_ff + {1'b0, top_entry.period};
      end

      cell_ctrl.shift      = advance;
      cell_ctrl.hold_below = remove ? IDX_FIELD_W'(kept_ff) : '0;
      cell_ctrl.load       = req_fire && is_add && !tbl_full;
      cell_ctrl.load_idx   = IDX_FIELD_W'(count_ff);
      cell_ctrl.load_entry.deadline = now_ff + {1'b0, req_data.offset_seconds};
      cell_ctrl.load_entry.period   = req_data.period_seconds;
      cell_ctrl.load_entry.action   = req_data.action_id;
      cell_ctrl.load_entry.param    = req_data.param_tag;

      rsp_load = 1'b0;
      rsp_next = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_add) begin
               rsp_load              = 1'b1;
               rsp_next.result_kind  = tbl_full ? KIND_FULL : KIND_ADDED;
               rsp_next.fired_action = req_data.action_id;
               rsp_next.fired_param  = req_data.param_tag;
               rsp_next.last         = 1'b1;
            end
         end
         ST_SCAN: begin
            // a newer hit pushes the held one out; it cannot be the last
            if (advance && need_out) begin
               rsp_load              = 1'b1;
               rsp_next.result_kind  = KIND_FIRED;
               rsp_next.fired_action = pend_action_ff;
               rsp_next.fired_param  = pend_param_ff;
               rsp_next.last         = 1'b0;
            end
         end
         ST_FLUSH: begin
            if (can_load) begin
               rsp_load              = 1'b1;
               rsp_next.result_kind  = KIND_FIRED;
               rsp_next.fired_action = pend_action_ff;
               rsp_next.fired_param  = pend_param_ff;
               rsp_next.last         = 1'b1;
            end
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b0;
         now_ff        <= '0;
         count_ff      <= '0;
         kept_ff       <= '0;
         step_ff       <= '0;
         fired_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            enable_ff <= csr_data;
         end
         if (tick_start) begin
            now_ff        <= now_ff + 32'd1;
            kept_ff       <= '0;
            step_ff       <= '0;
            fired_ff      <= '0;
            pend_valid_ff <= 1'b0;
         end
         if (cell_ctrl.load) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (advance) begin
            kept_ff <= kept_next;
            step_ff <= step_ff + IDX_W'(1);
            if (due_hit) begin
               fired_ff      <= fired_ff + FIRE_W'(1);
               pend_valid_ff <= 1'b1;
            end
            if (last_step) begin
               count_ff <= kept_next;
            end
         end
         if (state_ff == ST_FLUSH && can_load) begin
            pend_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && due_hit) begin
         pend_action_ff <= top_entry.action;
         pend_param_ff  <= top_entry.param;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

`default_nettype wire

// File: rtl/dtt_checker.sv
// ----------------------------------------------------------------------------
// dtt_checker
// Port-level checks of the deadline timer table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dtt_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_ready,
   input dtt_pkg::req_type  req_data,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input dtt_pkg::rsp_type  rsp_data,
   input wire               csr_valid,
   input wire               csr_ready
);
   import dtt_pkg::*;

   logic add_beat;

   assign add_beat = req_valid && req_ready && (req_data.command == CMD_ADD);

   // a waiting result beat holds
   `DTT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data))

   // an add is answered on the next cycle with a single final beat
   `DTT_ASSERT_NEXT(a_add_answer, clock, reset, add_beat,
      rsp_valid && rsp_data.last &&
      (rsp_data.result_kind == KIND_ADDED || rsp_data.result_kind == KIND_FULL))

   // the answer echoes the added id and tag
   `DTT_ASSERT_NEXT(a_add_echo, clock, reset, add_beat,
      rsp_data.fired_action == $past(req_data.action_id) &&
      rsp_data.fired_param == $past(req_data.param_tag))

   // only defined result kinds leave the block
   `DTT_ASSERT_NOW(a_kind_legal, clock, reset, rsp_valid,
      rsp_data.result_kind == KIND_FIRED || rsp_data.result_kind == KIND_ADDED ||
      rsp_data.result_kind == KIND_FULL)

   // register writes are taken at once
   `DTT_ASSERT_NOW(a_csr_ready, clock, reset, csr_valid, csr_ready)

endmodule

bind deadline_timer_table_core dtt_checker u_dtt_checker (.*);

`default_nettype wire

// File: sim/deadline_timer_table_core_test.sv
// ----------------------------------------------------------------------------
// deadline_timer_table_core_test
// Self-checking bench for the deadline timer table. An in-bench copy of the
// table state predicts every add and fire beat. A checker process compares
// each accepted rsp beat in order against the predicted beats. Directed
// tests are followed by random add and tick traffic, with sender bursts,
// receiver stalls and timer_enable toggling.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_table_core_test;

   import dtt_pkg::*;

   localparam int TABLE_DEPTH = 16;
   localparam int SCAN_SLACK  = 2 * TABLE_DEPTH + 4;
   localparam int STALL_LIMIT = 4000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data = 1'b0;

   // shadow of the block state
   logic        enable_shadow;
   logic [31:0] now_sec;
   int          entry_total;
   entry_type   timers [TABLE_DEPTH];

   rsp_type expected_beats [$];
   rsp_type want;
   int      err_count;
   int      quiet_cycles;
   int      burst_left;
   bit      valid_held;
   int      rx_cycle;

   deadline_timer_table_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------
   function automatic rsp_type make_beat(logic [1:0] kind, logic [7:0] act,
                                         logic [31:0] tag);
      rsp_type b;
      b.result_kind  = kind;
      b.fired_action = act;
      b.fired_param  = tag;
      b.last         = 1'b0;
      return b;
   endfunction

   function automatic void queue_beat(rsp_type b);
      expected_beats.insert(expected_beats.size(), b);
   endfunction

   function automatic void predict_timer_beats(req_type item);
      rsp_type fires [$];
      rsp_type b;
      int      i;
      if (item.command == CMD_ADD) begin
         if (entry_total >= TABLE_DEPTH) begin
            b = make_beat(KIND_FULL, item.action_id, item.param_tag);
         end else begin
            timers[entry_total].deadline = now_sec + {1'b0, item.offset_seconds};
            timers[entry_total].period   = item.period_seconds;
            timers[entry_total].action   = item.action_id;
            timers[entry_total].param    = item.param_tag;
            entry_total++;
            b = make_beat(KIND_ADDED, item.action_id, item.param_tag);
         end
         b.last = 1'b1;
         queue_beat(b);
         return;
      end
      if (!enable_shadow) return;
      now_sec = now_sec + 32'd1;
      i = entry_total;
      while (i > 0 && fires.size() < MAX_FIRES) begin
         i--;
         // wrap-aware: due when now - deadline is not negative
         if (!((now_sec - timers[i].deadline) >> 31)) begin
            fires.insert(fires.size(),
                         make_beat(KIND_FIRED, timers[i].action, timers[i].param));
            if (timers[i].period != '0) begin
               timers[i].deadline = now_sec + {1'b0, timers[i].period};
            end else begin
               for (int j = i; j + 1 < entry_total; j++) timers[j] = timers[j + 1];
               entry_total--;
            end
         end
      end
      if (fires.size() > 0) fires[fires.size() - 1].last = 1'b1;
      foreach (fires[k]) queue_beat(fires[k]);
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task automatic report_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            err_count++;
            $display("%0t: unexpected result beat, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            want = expected_beats.pop_front();
            report_field("result_kind", 32'(want.result_kind),
                         32'(rsp_data.result_kind));
            report_field("fired_action", 32'(want.fired_action),
                         32'(rsp_data.fired_action));
            report_field("fired_param", want.fired_param, rsp_data.fired_param);
            report_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
   end

   // receiver stall pattern: cycles through four modes, one without stalls
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 300) % 4)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (rx_cycle % 23) < 5;
         end
         default: begin
            rsp_ready <= $urandom_range(0, 7) != 0;
         end
      endcase
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic req_type make_add(logic [30:0] off, logic [30:0] per,
                                        logic [7:0] act, logic [31:0] tag);
      req_type r;
      r.command        = CMD_ADD;
      r.offset_seconds = off;
      r.period_seconds = per;
      r.action_id      = act;
      r.param_tag      = tag;
      return r;
   endfunction

   function automatic req_type make_tick();
      req_type r;
      r = make_add(31'($urandom()), 31'($urandom()), 8'($urandom()), $urandom());
      r.command = CMD_TICK;
      return r;
   endfunction

   task automatic send_command(req_type item);
      req_data <= item;
      if (!valid_held) req_valid <= 1'b1;
      valid_held = 1'b1;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      predict_timer_beats(item);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 12);
      end
   endtask

   // drop valid, drain all expected beats, then cover a silent scan
   task automatic settle_idle();
      if (valid_held) begin
         req_valid <= 1'b0;
         valid_held = 1'b0;
      end
      @(posedge clock);
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SCAN_SLACK) @(posedge clock);
   endtask

   task automatic write_enable(logic value);
      settle_idle();
      csr_data  <= value;
      csr_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      csr_valid <= 1'b0;
      enable_shadow = value;
      @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_disabled_ticks();
      send_command(make_tick());
      send_command(make_add('0, '0, 8'h00, 32'h0000_0000));
      send_command(make_tick());
   endtask

   task automatic test_full_table();
      write_enable(1'b1);
      // fire the entry added while disabled
      send_command(make_tick());
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         send_command(make_add('0, '0, 8'(8'h10 + k), $urandom()));
      end
      send_command(make_add('0, '0, 8'hFF, 32'hFFFF_FFFF));
      // every entry is due: the largest fire burst
      send_command(make_tick());
   endtask

   task automatic test_deadline_extremes();
      send_command(make_add('1, '0, 8'hFF, 32'hFFFF_FFFF));
      send_command(make_add('0, '1, 8'h5A, 32'hA5A5_5A5A));
      send_command(make_tick());
      send_command(make_tick());
   endtask

   task automatic test_enable_toggle();
      write_enable(1'b0);
      send_command(make_tick());
      write_enable(1'b1);
   endtask

   task automatic test_random_traffic();
      logic [30:0] off;
      logic [30:0] per;
      for (int round = 0; round < 4; round++) begin
         for (int k = 0; k < 85; k++) begin
            if ($urandom_range(0, 99) < 40) begin
               off = ($urandom_range(0, 9) < 7) ? 31'($urandom_range(0, 8))
                                                : 31'($urandom_range(9, 40));
               // keep periodic entries rare, they never leave the table
               per = ($urandom_range(0, 24) == 0) ? 31'($urandom_range(1, 30)) : '0;
               send_command(make_add(off, per, 8'($urandom()), $urandom()));
            end else begin
               send_command(make_tick());
            end
         end
         write_enable(1'b0);
         repeat (6) begin
            if ($urandom_range(0, 1)) send_command(make_tick());
            else send_command(make_add(31'($urandom_range(0, 8)), '0, 8'($urandom()),
                                       $urandom()));
         end
         write_enable(1'b1);
      end
   endtask

   initial begin
      enable_shadow = 1'b0;
      now_sec       = '0;
      entry_total   = 0;
      err_count     = 0;
      valid_held    = 1'b0;
      burst_left    = $urandom_range(1, 12);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled_ticks();
      test_full_table();
      test_deadline_extremes();
      test_enable_toggle();
      test_random_traffic();
      settle_idle();

      if (err_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: deadline_timer_table_core.f
+incdir+rtl
rtl/dtt_pkg.sv
rtl/dtt_cell.sv
rtl/deadline_timer_table_core.sv
rtl/dtt_checker.sv
sim/deadline_timer_table_core_test.sv
